// ===== hdl/imuma_pkg.sv =====
// Shared widths, codes and types for the three-axis IMU moving-average block.
// Used by every module in the hdl folder; depends on nothing else.
package imuma_pkg;

    // The window holds 2^WINDOW_LOG2 samples per axis and per sensor.
    localparam int WINDOW_LOG2 = 3;
    localparam int WINDOW_LEN  = 1 << WINDOW_LOG2;
    localparam int POS_W       = WINDOW_LOG2;

    localparam int NUM_AXES    = 3;
    localparam int NUM_SENSORS = 2;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + WINDOW_LOG2;
    localparam int DATA_W      = NUM_AXES * SAMPLE_W;

    // Sensor codes carried in tuser.
    localparam logic SENSOR_ACCEL = 1'b0;
    localparam logic SENSOR_GYRO  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSET_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSET_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSET_Z = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [POS_W-1:0]           pos_t;

    // Control of the stage between the lanes and the merging stage.
    typedef struct packed {
        logic valid;
        logic sensor;
    } stage_ctrl_t;

endpackage

// ===== hdl/imuma_lane.sv =====
// One axis lane: the sample histories of both sensors and their running sums.
// Depends on imuma_pkg.
module imuma_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    sensor,
    input  imuma_pkg::pos_t         wr_pos,
    input  imuma_pkg::sample_t      sample,
    output imuma_pkg::sum_t         sum
);

    imuma_pkg::sample_t hist_reg [imuma_pkg::NUM_SENSORS][imuma_pkg::WINDOW_LEN];
    imuma_pkg::sum_t    run_sum_reg [imuma_pkg::NUM_SENSORS];
    imuma_pkg::sum_t    sum_reg;
    imuma_pkg::sum_t    sum_next;
    imuma_pkg::sample_t oldest;

    // The running sum always equals the sum of the history, so swapping the
    // oldest entry for the new sample keeps it exact with one add and subtract.
    always_comb
    begin
        oldest   = hist_reg[sensor][wr_pos];
        sum_next = run_sum_reg[sensor]
                 - {{(imuma_pkg::SUM_W - imuma_pkg::SAMPLE_W){oldest[imuma_pkg::SAMPLE_W-1]}},
                    oldest}
                 + {{(imuma_pkg::SUM_W - imuma_pkg::SAMPLE_W){sample[imuma_pkg::SAMPLE_W-1]}},
                    sample};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < imuma_pkg::NUM_SENSORS; s++)
            begin
                run_sum_reg[s] <= '0;
                for (int i = 0; i < imuma_pkg::WINDOW_LEN; i++)
                begin
                    hist_reg[s][i] <= '0;
                end
            end
        end
        else if (accept)
        begin
            hist_reg[sensor][wr_pos] <= sample;
            run_sum_reg[sensor]      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== hdl/imuma_merge.sv =====
// Merging stage: averages the lane sums, removes the gyroscope offsets with
// saturation and holds the result in the output register. Depends on imuma_pkg.
module imuma_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imuma_pkg::stage_ctrl_t              stage,
    input  imuma_pkg::sum_t                     sums [imuma_pkg::NUM_AXES],
    input  imuma_pkg::sample_t                  offsets [imuma_pkg::NUM_AXES],
    output logic                                load,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [imuma_pkg::DATA_W-1:0]        m_axis_tdata,  // x_filtered, y_filtered, z_filtered
    output logic                                m_axis_tuser   // result_sensor
);

    logic                          tvalid_reg;
    logic                          tvalid_next;
    logic                          tuser_reg;
    logic [imuma_pkg::DATA_W-1:0]  tdata_reg;
    logic [imuma_pkg::DATA_W-1:0]  tdata_next;

    assign load = !tvalid_reg || m_axis_tready;

    always_comb
    begin
        tvalid_next = tvalid_reg;
        if (load)
        begin
            tvalid_next = stage.valid;
        end
    end

    for (genvar a = 0; a < imuma_pkg::NUM_AXES; a++)
    begin : g_axis
        imuma_pkg::sum_t                   shifted;
        imuma_pkg::sample_t                avg;
        logic signed [imuma_pkg::SAMPLE_W:0] diff;
        imuma_pkg::sample_t                corrected;

        // Arithmetic shift floors the average; it always fits in a sample.
        assign shifted = sums[a] >>> imuma_pkg::WINDOW_LOG2;
        assign avg     = shifted[imuma_pkg::SAMPLE_W-1:0];
        assign diff    = {avg[imuma_pkg::SAMPLE_W-1], avg}
                       - {offsets[a][imuma_pkg::SAMPLE_W-1], offsets[a]};

        always_comb
        begin
            if (diff[imuma_pkg::SAMPLE_W] != diff[imuma_pkg::SAMPLE_W-1])
            begin
                corrected = diff[imuma_pkg::SAMPLE_W]
                          ? {1'b1, {(imuma_pkg::SAMPLE_W-1){1'b0}}}
                          : {1'b0, {(imuma_pkg::SAMPLE_W-1){1'b1}}};
            end
            else
            begin
                corrected = diff[imuma_pkg::SAMPLE_W-1:0];
            end
        end

        assign tdata_next[a*imuma_pkg::SAMPLE_W +: imuma_pkg::SAMPLE_W] =
            (stage.sensor == imuma_pkg::SENSOR_GYRO) ? corrected : avg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && stage.valid)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= stage.sensor;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

// ===== hdl/imu_three_axis_moving_average_top.sv =====
// Top level of the three-axis IMU moving-average filter: configuration
// registers, write positions, three axis lanes and the merging stage.
// Depends on imuma_pkg, imuma_lane and imuma_merge.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: sensor_select; tdata: x_sample, y_sample, z_sample
//  m_axis    out        tuser: result_sensor; tdata: x_filtered, y_filtered, z_filtered
//  cfg       in         cfg_index selects gyro_offset_x/y/z, cfg_data is the value
//
// One transaction is accepted per cycle unless the lane stage is full and the output is
// stalled; a result reaches the output through the lane stage and then the output register.
// The running-sum update in each lane sets the rate.
// Reset clears the histories, running sums, write positions and offsets at once.
// A stalled output holds its result; the lane stage keeps accepting until it too is full.
module imu_three_axis_moving_average_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [imuma_pkg::DATA_W-1:0]          s_axis_tdata,  // x_sample, y_sample, z_sample
    input  logic                                  s_axis_tuser,  // sensor_select
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [imuma_pkg::DATA_W-1:0]          m_axis_tdata,  // x_filtered, y_filtered, z_filtered
    output logic                                  m_axis_tuser,  // result_sensor
    input  logic                                  cfg_wr_en,
    input  logic [imuma_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [imuma_pkg::SAMPLE_W-1:0]        cfg_data
);

    imuma_pkg::sample_t      offset_reg [imuma_pkg::NUM_AXES];
    imuma_pkg::pos_t         pos_reg [imuma_pkg::NUM_SENSORS];
    imuma_pkg::stage_ctrl_t  stage_reg;
    imuma_pkg::stage_ctrl_t  stage_next;
    imuma_pkg::sum_t         sums [imuma_pkg::NUM_AXES];
    logic                    load;
    logic                    accept;

    assign s_axis_tready = !stage_reg.valid || load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        stage_next = stage_reg;
        if (s_axis_tready)
        begin
            stage_next.valid  = s_axis_tvalid;
            stage_next.sensor = s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            for (int s = 0; s < imuma_pkg::NUM_SENSORS; s++)
            begin
                pos_reg[s] <= '0;
            end
            for (int a = 0; a < imuma_pkg::NUM_AXES; a++)
            begin
                offset_reg[a] <= '0;
            end
        end
        else
        begin
            stage_reg <= stage_next;
            if (accept)
            begin
                pos_reg[s_axis_tuser] <= pos_reg[s_axis_tuser] + 1'b1;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    imuma_pkg::REG_GYRO_OFFSET_X: offset_reg[0] <= cfg_data;
                    imuma_pkg::REG_GYRO_OFFSET_Y: offset_reg[1] <= cfg_data;
                    imuma_pkg::REG_GYRO_OFFSET_Z: offset_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    for (genvar a = 0; a < imuma_pkg::NUM_AXES; a++)
    begin : g_lane
        imuma_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .sensor (s_axis_tuser),
            .wr_pos (pos_reg[s_axis_tuser]),
            .sample (s_axis_tdata[a*imuma_pkg::SAMPLE_W +: imuma_pkg::SAMPLE_W]),
            .sum    (sums[a])
        );
    end

    imuma_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage_reg),
        .sums          (sums),
        .offsets       (offset_reg),
        .load          (load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== hdl/imuma_checker.sv =====
// Port-level checks on the moving-average top level, and the bind that
// attaches them. Depends on imuma_pkg and imu_three_axis_moving_average_top.
module imuma_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [imuma_pkg::DATA_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tuser
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output transaction changed while stalled");

    // With an empty output register the block must be ready for input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready although output register is empty");

    // A flowing pipe presents the result once it has passed the lane stage and the output register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc ##1 m_axis_tready) |=> m_axis_tvalid)
        else $error("result missing two cycles after acceptance");

    a_sensor_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc ##1 m_axis_tready) |=> (m_axis_tuser == $past(s_axis_tuser, 2)))
        else $error("result sensor does not match the accepted transaction");

endmodule

bind imu_three_axis_moving_average_top imuma_checker u_imuma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
